// ===== hdl/trd_pkg.sv =====
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants of the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package trd_pkg;

  // Default color map depth.
  localparam int unsigned MAP_ENTRIES_DEF = 256;

  // Reset value of the bytes-per-pixel register.
  localparam logic [2:0] PIXEL_BYTES_RST = 3'd3;

  // Packet header layout: bit 7 selects a run packet, bits 6..0 hold count - 1.
  localparam int unsigned HDR_RUN_BIT = 7;

  // Function codes of an input transaction.
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_MAP   = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_PIXEL_BYTES  = 2'd0,
    CFG_RLE_MODE     = 2'd1,
    CFG_CMAP_EN      = 2'd2,
    CFG_PIXEL_TOTAL  = 2'd3
  } cfg_idx_t;

  // Configuration register contents.
  typedef struct packed {
    logic [2:0]  pixel_bytes;
    logic        rle_mode;
    logic        cmap_en;
    logic [31:0] pixel_total;
  } cfg_t;

  // One decoded pixel result handed from the packet controller.
  typedef struct packed {
    logic [31:0] value;   // raw pixel value, or map index; zero when bad
    logic [7:0]  count;   // repeat count, 1..128
    logic        eoi;     // completes the image
    logic        bad;     // map index beyond the color map
    logic        lookup;  // value is replaced by the color map entry
  } res_t;

endpackage

// ===== hdl/trd_if.sv =====
// ----------------------------------------------------------------------------
// trd_in_if / trd_out_if
// Valid/ready channels of the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
interface trd_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  stream_byte;
  logic [7:0]  map_index;
  logic [31:0] map_entry;

  modport source (output valid, func, stream_byte, map_index, map_entry, input ready);
  modport sink   (input valid, func, stream_byte, map_index, map_entry, output ready);
endinterface

interface trd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic [7:0]  repeat_count;
  logic        end_of_image;
  logic        bad_index;

  modport source (output valid, pixel_value, repeat_count, end_of_image, bad_index,
                  input ready);
  modport sink   (input valid, pixel_value, repeat_count, end_of_image, bad_index,
                  output ready);
endinterface

// ===== hdl/trd_cmap.sv =====
// ----------------------------------------------------------------------------
// trd_cmap
// Color map memory: one synchronous write port, one registered read port.
// ----------------------------------------------------------------------------
module trd_cmap #(
  parameter int unsigned ENTRIES = trd_pkg::MAP_ENTRIES_DEF,
  parameter int unsigned AW      = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [ENTRIES];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/trd_ctrl.sv =====
// ----------------------------------------------------------------------------
// trd_ctrl
// Packet and pixel assembly state; produces one result per completed pixel.
// ----------------------------------------------------------------------------
module trd_ctrl #(
  parameter int unsigned MAP_ENTRIES = trd_pkg::MAP_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  trd_pkg::cfg_t       cfg,
  input  logic                byte_en,
  input  logic [7:0]          stream_byte,
  output logic                res_valid,
  output trd_pkg::res_t       res
);

  localparam logic [31:0] MAP_LIMIT = 32'(MAP_ENTRIES);

  logic        expect_hdr_r, expect_hdr_nxt;
  logic        run_pkt_r, run_pkt_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] done_r, done_nxt;

  logic [2:0]  nbytes;
  logic [2:0]  pos_inc;
  logic [31:0] acc_new;
  logic [7:0]  left_eff;
  logic [7:0]  count;
  logic [31:0] remaining;
  logic        eoi;
  logic        bad;

  always_comb begin
    expect_hdr_nxt = expect_hdr_r;
    run_pkt_nxt    = run_pkt_r;
    left_nxt       = left_r;
    pos_nxt        = pos_r;
    acc_nxt        = acc_r;
    done_nxt       = done_r;
    res_valid      = 1'b0;
    res            = '0;
    eoi            = 1'b0;
    bad            = 1'b0;
    count          = 8'd1;

    if (cfg.pixel_bytes == 3'd0) begin
      nbytes = 3'd1;
    end else if (cfg.pixel_bytes > 3'd4) begin
      nbytes = 3'd4;
    end else begin
      nbytes = cfg.pixel_bytes;
    end
    pos_inc   = {1'b0, pos_r} + 3'd1;
    acc_new   = acc_r | (32'(stream_byte) << {pos_r, 3'b000});
    left_eff  = (left_r == 8'd0) ? 8'd1 : left_r;
    remaining = cfg.pixel_total - done_r;

    if (byte_en && (cfg.pixel_total != 32'd0)) begin
      if (cfg.rle_mode && expect_hdr_r) begin
        run_pkt_nxt    = stream_byte[trd_pkg::HDR_RUN_BIT];
        left_nxt       = {1'b0, stream_byte[6:0]} + 8'd1;
        expect_hdr_nxt = 1'b0;
        pos_nxt        = 2'd0;
        acc_nxt        = '0;
      end else if (pos_inc < nbytes) begin
        pos_nxt = pos_r + 2'd1;
        acc_nxt = acc_new;
      end else begin
        pos_nxt = 2'd0;
        acc_nxt = '0;
        bad     = cfg.cmap_en && (acc_new >= MAP_LIMIT);

        if (cfg.rle_mode) begin
          if (run_pkt_r) begin
            count          = left_eff;
            left_nxt       = 8'd0;
            expect_hdr_nxt = 1'b1;
          end else begin
            left_nxt       = left_eff - 8'd1;
            expect_hdr_nxt = (left_eff == 8'd1);
          end
        end

        // Clip the run at the end of the image.
        if (done_r >= cfg.pixel_total) begin
          count = 8'd1;
          eoi   = 1'b1;
        end else if (32'(count) >= remaining) begin
          count = remaining[7:0];
          eoi   = 1'b1;
        end

        if (eoi) begin
          done_nxt       = '0;
          expect_hdr_nxt = 1'b1;
          run_pkt_nxt    = 1'b0;
          left_nxt       = 8'd0;
        end else begin
          done_nxt = done_r + 32'(count);
        end

        res_valid  = 1'b1;
        res.value  = bad ? 32'd0 : acc_new;
        res.count  = count;
        res.eoi    = eoi;
        res.bad    = bad;
        res.lookup = cfg.cmap_en && !bad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_hdr_r <= 1'b1;
      run_pkt_r    <= 1'b0;
      left_r       <= 8'd0;
      pos_r        <= 2'd0;
      acc_r        <= '0;
      done_r       <= '0;
    end else begin
      expect_hdr_r <= expect_hdr_nxt;
      run_pkt_r    <= run_pkt_nxt;
      left_r       <= left_nxt;
      pos_r        <= pos_nxt;
      acc_r        <= acc_nxt;
      done_r       <= done_nxt;
    end
  end

  // A run never exceeds one packet's worth of pixels.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res.count != 8'd0) && (res.count <= 8'd128))
    else $error("trd_ctrl: repeat count out of range");

  // Completing the image always rearms for a packet header.
  a_eoi_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.eoi) |=> (expect_hdr_r && (done_r == 32'd0) && (left_r == 8'd0)))
    else $error("trd_ctrl: frame state not rearmed after end of image");

  // Partial pixel assembly never runs past four bytes.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, pos_r} < nbytes) || !byte_en || (cfg.pixel_total == 32'd0) ||
    (cfg.rle_mode && expect_hdr_r) || res_valid)
    else $error("trd_ctrl: byte position beyond pixel size");

endmodule

// ===== hdl/tga_rle_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// TGA pixel-data decoder with run-length packets and a color map.
// ----------------------------------------------------------------------------
// The decoder takes one input transaction per clock, every clock, as long as
// the result side keeps up: either one byte of the TGA pixel-data stream or
// one color map write. A result is registered in the cycle after the byte
// that completes a pixel, together with the registered read of the color map
// memory, read for every completed pixel and used if color mapping is on and
// the index fits. A run packet produces a single result carrying its repeat
// count, clipped at the configured pixel total. The result register frees up
// in the same cycle its transaction completes, so a stalled result blocks new
// input only while it waits. The user must write configuration registers
// through the cfg port only while the block is idle; the block does not
// enforce it. Frame state survives configuration writes. After the result
// that completes the image the block rearms for the next frame. The color
// map has no reset; an entry never written reads as an unspecified value.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
  parameter int unsigned MAP_ENTRIES = trd_pkg::MAP_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  trd_in_if.sink      in_chan,
  trd_out_if.source   out_chan
);

  localparam int unsigned AW = $clog2(MAP_ENTRIES);

  // Configuration registers.
  trd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_bytes  <= trd_pkg::PIXEL_BYTES_RST;
      cfg_r.rle_mode     <= 1'b0;
      cfg_r.cmap_en      <= 1'b0;
      cfg_r.pixel_total  <= '0;
    end else if (cfg_we) begin
      case (trd_pkg::cfg_idx_t'(cfg_index))
        trd_pkg::CFG_PIXEL_BYTES:  cfg_r.pixel_bytes  <= cfg_wdata[2:0];
        trd_pkg::CFG_RLE_MODE:     cfg_r.rle_mode     <= cfg_wdata[0];
        trd_pkg::CFG_CMAP_EN:      cfg_r.cmap_en      <= cfg_wdata[0];
        trd_pkg::CFG_PIXEL_TOTAL:  cfg_r.pixel_total  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input transaction handshake. The result register is free when empty or
  // when its transaction completes in this cycle.
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic byte_en;
  logic map_wr;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign byte_en       = accept && (in_chan.func == trd_pkg::FUNC_PIXEL);
  assign map_wr        = accept && (in_chan.func == trd_pkg::FUNC_MAP) &&
                         (32'(in_chan.map_index) < 32'(MAP_ENTRIES));

  // Packet and pixel assembly.
  logic          res_valid;
  trd_pkg::res_t res;

  trd_ctrl #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .byte_en    (byte_en),
    .stream_byte(in_chan.stream_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Color map. The read is issued with the completing byte, so its data is
  // registered alongside the result register. Writes and reads come from
  // separate transactions in order, so a read always sees earlier writes.
  logic [31:0] map_data;

  trd_cmap #(
    .ENTRIES(MAP_ENTRIES),
    .AW     (AW)
  ) u_cmap (
    .clk    (clk),
    .wr_en  (map_wr),
    .wr_addr(AW'(in_chan.map_index)),
    .wr_data(in_chan.map_entry),
    .rd_en  (res_valid),
    .rd_addr(AW'(res.value)),
    .rd_data(map_data)
  );

  // Result register.
  trd_pkg::res_t res_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = res_valid;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.pixel_value  = res_r.lookup ? map_data : res_r.value;
  assign out_chan.repeat_count = res_r.count;
  assign out_chan.end_of_image = res_r.eoi;
  assign out_chan.bad_index    = res_r.bad;

  // A color map write never produces a result.
  a_map_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_chan.func == trd_pkg::FUNC_MAP)) |=> !out_valid_r)
    else $error("tga_rle_pixel_decoder: result after a map write");

  // A bad index always reads as pixel zero.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.bad) |-> (out_chan.pixel_value == 32'd0) && !res_r.lookup)
    else $error("tga_rle_pixel_decoder: bad index with nonzero pixel");

  // Bad indexes only occur in color-mapped mode.
  a_bad_mapped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.bad) |-> cfg_r.cmap_en)
    else $error("tga_rle_pixel_decoder: bad index outside color-mapped mode");

endmodule

// ===== tb/sv/tga_rle_pixel_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_tb
// Self-checking testbench of the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
// A short directed sequence covers zero and clipped totals, full and clipped
// runs, color map hits and misses, header bytes that drop a partial pixel,
// and a total lowered below the pixels already done. Random phases follow,
// each with a fresh register setting, made mostly of well-formed packets and
// pixels with a sprinkling of stray bytes and map writes. A scoreboard class
// mirrors the decoder state, predicts every result and checks each result
// transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAP_DEPTH    = trd_pkg::MAP_ENTRIES_DEF;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned SETTLE       = 8;     // cycles the block may still be busy
  localparam int unsigned TAIL         = 20;    // quiet cycles before the verdict
  localparam int unsigned STALL_LIMIT  = 4000;  // cycles without any transaction

  // One expected result transaction.
  typedef struct {
    logic [31:0] value;
    logic [7:0]  count;
    logic        eoi;
    logic        bad;
  } pixel_res_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  trd_in_if  in_chan ();
  trd_out_if out_chan ();

  // Idle rates of the two sides, in percent of cycles.
  int unsigned send_gap_pct;
  int unsigned take_gap_pct;
  // Input transactions that the decoder actually acts on.
  int unsigned items_sent;

  // --------------------------------------------------------------------------
  // Scoreboard: a mirror of the decoder's registers and frame state that
  // turns each accepted input transaction into the result it should cause,
  // and matches result transactions against those predictions in order.
  // --------------------------------------------------------------------------
  class pixel_tracker;
    bit [2:0]    pix_bytes;
    bit          rle_on;
    bit          map_on;
    bit [31:0]   pix_total;
    bit          want_header;
    bit          run_pkt;
    int unsigned pkt_left;
    int unsigned byte_pos;
    bit [31:0]   accum;
    bit [31:0]   pix_done;
    bit [31:0]   color_map [MAP_DEPTH];
    pixel_res_t  awaited [$];
    int unsigned mismatches;

    function new();
      pix_bytes   = trd_pkg::PIXEL_BYTES_RST;
      rle_on      = 1'b0;
      map_on      = 1'b0;
      pix_total   = '0;
      want_header = 1'b1;
      run_pkt     = 1'b0;
      pkt_left    = 0;
      byte_pos    = 0;
      accum       = '0;
      pix_done    = '0;
      mismatches  = 0;
      foreach (color_map[i]) color_map[i] = '0;
    endfunction

    function void set_reg(trd_pkg::cfg_idx_t idx, logic [31:0] data);
      case (idx)
        trd_pkg::CFG_PIXEL_BYTES: pix_bytes = data[2:0];
        trd_pkg::CFG_RLE_MODE:    rle_on    = data[0];
        trd_pkg::CFG_CMAP_EN:     map_on    = data[0];
        trd_pkg::CFG_PIXEL_TOTAL: pix_total = data;
        default: ;
      endcase
    endfunction

    // Out-of-range byte counts saturate: zero acts as one, above four as four.
    function int unsigned pixel_width();
      if (pix_bytes == 3'd0) return 1;
      if (pix_bytes > 3'd4) return 4;
      return 32'(pix_bytes);
    endfunction

    function void note_item(logic func, logic [7:0] b, logic [7:0] midx,
                            logic [31:0] mval);
      bit [31:0]  value;
      bit [31:0]  count;
      bit [31:0]  remaining;
      bit         bad;
      bit         eoi;
      pixel_res_t res;
      bad = 1'b0;
      eoi = 1'b0;
      if (func == trd_pkg::FUNC_MAP) begin
        if (midx < MAP_DEPTH) color_map[midx] = mval;
        return;
      end
      if (pix_total == 0) return;
      if (rle_on && want_header) begin
        run_pkt     = b[trd_pkg::HDR_RUN_BIT];
        pkt_left    = b[6:0] + 1;
        want_header = 1'b0;
        byte_pos    = 0;
        accum       = '0;
        return;
      end
      accum |= 32'(b) << (8 * byte_pos);
      if (byte_pos + 1 < pixel_width()) begin
        byte_pos++;
        return;
      end
      value    = accum;
      accum    = '0;
      byte_pos = 0;
      if (map_on) begin
        if (value < MAP_DEPTH) begin
          value = color_map[value];
        end else begin
          value = '0;
          bad   = 1'b1;
        end
      end
      count = 1;
      if (rle_on) begin
        if (pkt_left == 0) pkt_left = 1;
        if (run_pkt) begin
          count       = pkt_left;
          pkt_left    = 0;
          want_header = 1'b1;
        end else begin
          pkt_left--;
          if (pkt_left == 0) want_header = 1'b1;
        end
      end
      // A total lowered below the pixels already done ends the frame at once.
      if (pix_done >= pix_total) begin
        count = 1;
        eoi   = 1'b1;
      end else begin
        remaining = pix_total - pix_done;
        if (count >= remaining) begin
          count = remaining;
          eoi   = 1'b1;
        end
      end
      if (eoi) begin
        pix_done    = '0;
        want_header = 1'b1;
        run_pkt     = 1'b0;
        pkt_left    = 0;
      end else begin
        pix_done += count;
      end
      res.value = value;
      res.count = count[7:0];
      res.eoi   = eoi;
      res.bad   = bad;
      awaited.push_back(res);
    endfunction

    function void check_pixel(logic [31:0] value, logic [7:0] count, logic eoi,
                              logic bad);
      pixel_res_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: pixel_value %h repeat_count %0d", value, count);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (value !== want.value) begin
        $error("pixel_value mismatch: expected %h, actual %h", want.value, value);
        mismatches++;
      end
      if (count !== want.count) begin
        $error("repeat_count mismatch: expected %0d, actual %0d", want.count, count);
        mismatches++;
      end
      if (eoi !== want.eoi) begin
        $error("end_of_image mismatch: expected %b, actual %b", want.eoi, eoi);
        mismatches++;
      end
      if (bad !== want.bad) begin
        $error("bad_index mismatch: expected %b, actual %b", want.bad, bad);
        mismatches++;
      end
    endfunction
  endclass

  pixel_tracker tracker;

  tga_rle_pixel_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // --------------------------------------------------------------------------
  // Result side. Ready is redrawn at every falling edge from the current idle
  // rate; a result transaction is checked at the rising edge it completes on.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= take_gap_pct);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      tracker.check_pixel(out_chan.pixel_value, out_chan.repeat_count,
                          out_chan.end_of_image, out_chan.bad_index);
    end
  end

  // --------------------------------------------------------------------------
  // Input side. Every task below starts and ends at a falling edge. An input
  // transaction is handed to the scoreboard at the rising edge that accepts
  // it, so the prediction always uses the register state the block sees.
  // --------------------------------------------------------------------------
  task automatic send_item(logic func, logic [7:0] b, logic [7:0] midx,
                           logic [31:0] mval);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.func        <= func;
    in_chan.stream_byte <= b;
    in_chan.map_index   <= midx;
    in_chan.map_entry   <= mval;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    // Bytes dropped under a zero pixel total do not count as work.
    if (func == trd_pkg::FUNC_MAP || tracker.pix_total != 0) items_sent++;
    tracker.note_item(func, b, midx, mval);
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(trd_pkg::FUNC_PIXEL, b, 8'($urandom), $urandom);
  endtask

  task automatic send_map(logic [7:0] midx, logic [31:0] mval);
    send_item(trd_pkg::FUNC_MAP, 8'($urandom), midx, mval);
  endtask

  // Sends one stored pixel value, least significant byte first, at the byte
  // count currently in effect.
  task automatic send_pixel(logic [31:0] value);
    for (int unsigned k = 0; k < tracker.pixel_width(); k++) begin
      send_byte(value[8 * k +: 8]);
    end
  endtask

  // Holds the input idle until every predicted result has arrived, then lets
  // a few more cycles pass for work that produces no result.
  task automatic drain(int unsigned settle);
    in_chan.valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_cfg(trd_pkg::cfg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Registers are only written once the block has gone quiet.
  task automatic configure(logic [2:0] pb, logic rle, logic cmap, logic [31:0] total);
    drain(SETTLE);
    write_cfg(trd_pkg::CFG_PIXEL_BYTES, {29'd0, pb});
    write_cfg(trd_pkg::CFG_RLE_MODE, {31'd0, rle});
    write_cfg(trd_pkg::CFG_CMAP_EN, {31'd0, cmap});
    write_cfg(trd_pkg::CFG_PIXEL_TOTAL, total);
  endtask

  // In color-mapped mode most values land inside the map so that lookups
  // dominate; the rest fall off the end and exercise the bad index flag.
  function automatic logic [31:0] rand_pixel();
    if (tracker.map_on && $urandom_range(0, 9) != 0) return $urandom_range(0, MAP_DEPTH - 1);
    return $urandom;
  endfunction

  task automatic random_setup();
    logic [2:0]  pb;
    logic [31:0] total;
    int unsigned pick;
    int unsigned odd;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // Byte counts outside 1..4 saturate inside the block.
      odd = $urandom_range(0, 3);
      pb  = (odd == 0) ? 3'd0 : 3'(4 + odd);
    end else begin
      pb = 3'($urandom_range(1, 4));
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) total = 32'd0;
    else if (pick < 14) total = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd4294836225;
    else if (pick < 20) total = $urandom;
    else if (pick < 28) total = $urandom_range(1, 4);
    else total = $urandom_range(5, 300);
    configure(pb, 1'($urandom_range(0, 1)), ($urandom_range(0, 2) == 0), total);
  endtask

  // One random phase under the current setting. Packets follow the mirrored
  // decoder state, so a header is only sent when one is awaited and a raw
  // packet stops early once the frame has ended.
  task automatic run_phase(int unsigned length);
    int unsigned goal;
    int unsigned pause_at;
    int unsigned pick;
    int unsigned cnt;
    bit          run;
    bit          do_pause;
    goal     = items_sent + length;
    pause_at = items_sent + $urandom_range(1, length);
    do_pause = ($urandom_range(0, 3) == 0);
    if (tracker.pix_total == 0) begin
      repeat (6) send_byte(8'($urandom));
      return;
    end
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_map(8'($urandom), $urandom);
      end else if (pick < 10) begin
        send_byte(8'($urandom));
      end else if (tracker.rle_on && tracker.want_header) begin
        run = $urandom_range(0, 1);
        if (run) cnt = $urandom_range(1, 128);
        else if ($urandom_range(0, 19) == 0) cnt = $urandom_range(1, 128);
        else cnt = $urandom_range(1, 6);
        send_byte({run, 7'(cnt - 1)});
        if (run) begin
          send_pixel(rand_pixel());
        end else begin
          for (int unsigned k = 0; k < cnt; k++) begin
            if (!tracker.rle_on || tracker.want_header) break;
            send_pixel(rand_pixel());
          end
        end
      end else begin
        send_pixel(rand_pixel());
      end
      // Now and then the sender waits for every outstanding result.
      if (do_pause && items_sent >= pause_at) begin
        drain(1);
        do_pause = 1'b0;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Watchdog: the run is declared failed once no transaction has completed
  // on either channel before the watchdog limit runs out.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
          (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned base;
    tracker             = new();
    send_gap_pct        = 34;
    take_gap_pct        = 86;
    items_sent          = 0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = trd_pkg::CFG_PIXEL_BYTES;
    cfg_wdata           = '0;
    in_chan.valid       = 1'b0;
    in_chan.func        = trd_pkg::FUNC_PIXEL;
    in_chan.stream_byte = '0;
    in_chan.map_index   = '0;
    in_chan.map_entry   = '0;
    out_chan.ready      = 1'b0;

    // Synchronous reset, released at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The color map has no reset, so every entry is loaded before any lookup.
    for (int i = 0; i < MAP_DEPTH; i++) send_map(8'(i), $urandom);

    // Zero pixel total: stream bytes are dropped with no result. Then three
    // one-byte pixels, two at the byte extremes, the last one ending the frame.
    configure(3'd1, 1'b0, 1'b0, 32'd0);
    send_byte(8'h5A);
    configure(3'd1, 1'b0, 1'b0, 32'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h81);

    // Four-byte pixels in run packets: a full 128-pixel run, then a second
    // one clipped to the 72 pixels left in the frame.
    configure(3'd4, 1'b1, 1'b0, 32'd200);
    send_byte(8'hFF);
    send_pixel(32'hFFFF_FFFF);
    send_byte(8'hFF);
    send_pixel(32'h0000_0000);

    // Two-byte color map indexes: the top entry, then one past the map.
    configure(3'd2, 1'b0, 1'b1, 32'd3);
    send_pixel(32'h0000_00FF);
    send_pixel(32'h0000_0100);
    // A lone byte leaves a partial pixel, which the next packet header
    // discards once packet mode is switched on.
    send_byte(8'h07);
    configure(3'd2, 1'b1, 1'b1, 32'd3);
    send_byte(8'h80);
    send_pixel(32'h0000_0003);

    // The total is lowered below the pixels already done in this frame, so
    // the next pixel ends the frame with a count of one.
    configure(3'd1, 1'b0, 1'b0, 32'd10);
    repeat (4) send_byte(8'($urandom));
    configure(3'd1, 1'b0, 1'b0, 32'd2);
    send_byte(8'($urandom));

    // Random phases under three idle profiles: a slow receiver, a slow
    // sender, and finally both sides at full rate.
    base = items_sent;
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_gap_pct = 34;
          take_gap_pct = 86;
        end
        1: begin
          send_gap_pct = 86;
          take_gap_pct = 34;
        end
        default: begin
          send_gap_pct = 0;
          take_gap_pct = 0;
        end
      endcase
      while (items_sent < base + (p + 1) * RANDOM_ITEMS / 3) begin
        random_setup();
        run_phase($urandom_range(30, 120));
      end
    end

    // Wait for the last results, then stay quiet long enough for any
    // stray result to show up as unexpected.
    drain(TAIL);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== tga_rle_pixel_decoder.f =====
hdl/trd_pkg.sv
hdl/trd_if.sv
hdl/trd_cmap.sv
hdl/trd_ctrl.sv
hdl/tga_rle_pixel_decoder.sv
tb/sv/tga_rle_pixel_decoder_tb.sv
